// ----- src/sqdj_pkg.sv -----
// ---------------------------------------------------------------------------
// sqdj_pkg: shared types and constants for the shortest-queue dispatcher
// Holds the transaction payload structures, status codes and the register
// indices of the configuration port.
// ---------------------------------------------------------------------------
package sqdj_pkg;

	typedef struct packed {
		logic        kind;
		logic [15:0] customer_id;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  queue_index;
		logic        jockey_moved;
		logic [2:0]  jockey_target;
		logic [15:0] moved_id;
	} out_t;

	localparam logic KIND_ARRIVAL   = 1'b0;
	localparam logic KIND_DEPARTURE = 1'b1;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

	localparam logic REG_ACTIVE_QUEUES    = 1'b0;
	localparam logic REG_JOCKEY_THRESHOLD = 1'b1;

	localparam logic [3:0] ACTIVE_QUEUES_RESET    = 4'd8;
	localparam logic [3:0] JOCKEY_THRESHOLD_RESET = 4'd2;

endpackage

// ----- src/shortest_queue_dispatch_with_jockeying_core.sv -----
// ---------------------------------------------------------------------------
// shortest_queue_dispatch_with_jockeying_core: join-shortest-queue dispatcher
// Keeps FIFO queues of customer identifiers. Arrivals join the shortest
// active queue, departures pop the matching head, and a pop may move the
// origin's tail customer to a nearby, much shorter queue.
// ---------------------------------------------------------------------------
// Channel   Signals                                  Transfer
// command   start, busy, item                        start high, busy low
// result    done, result                             done high, one cycle
// config    psel, penable, pwrite, paddr, pwdata,     psel, penable, pwrite
//           prdata, pready                            and pready high
//
// A sequencer walks the queues one per cycle through a single length
// compare and one store port; the scans over the queue lengths and the
// one-read store set how long a transaction lasts. Busy stays high for
// the whole transaction. Reset clears lengths, head pointers and
// registers; the store itself is not cleared. Results cannot be held off.
// ---------------------------------------------------------------------------
module shortest_queue_dispatch_with_jockeying_core
	import sqdj_pkg::*;
#(
	parameter int NUM_QUEUES  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_t         item,
	output logic        done,
	output out_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int QW = $clog2(NUM_QUEUES);
	localparam int CW = $clog2(NUM_QUEUES + 1);
	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int PW = SW + 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW = (LW > 4) ? LW : 4;
	localparam int AW = QW + SW;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ASCAN = 8'b0000_0010,
		S_AWR   = 8'b0000_0100,
		S_DSCAN = 8'b0000_1000,
		S_DPOP  = 8'b0001_0000,
		S_JSCAN = 8'b0010_0000,
		S_JRD   = 8'b0100_0000,
		S_JWR   = 8'b1000_0000
	} state_t;

	function automatic logic [SW-1:0] wrap_slot(input logic [PW-1:0] s);
		logic [PW-1:0] r;
		r = (s >= PW'(QUEUE_DEPTH)) ? s - PW'(QUEUE_DEPTH) : s;
		return r[SW-1:0];
	endfunction

	state_t state_q;

	logic [3:0] act_q;
	logic [3:0] thr_q;

	logic [SW-1:0] head_q [NUM_QUEUES];
	logic [LW-1:0] len_q  [NUM_QUEUES];

	logic [CW-1:0]       cnt_q;
	logic [ID_WIDTH-1:0] id_q;

	logic [QW-1:0] best_q;
	logic [SW-1:0] best_head_q;
	logic [LW-1:0] best_len_q;
	logic [QW-1:0] best_dist_q;
	logic          have_q;

	logic [QW-1:0] org_q;
	logic [SW-1:0] org_head_q;
	logic [LW-1:0] org_len_q;
	logic          found_q;

	logic          p_vld_s1;
	logic [QW-1:0] p_idx_s1;
	logic [SW-1:0] p_head_s1;
	logic [LW-1:0] p_len_s1;

	logic done_q;
	out_t res_q;

	logic [CW-1:0]       used_n;
	logic [QW-1:0]       idx;
	logic [LW-1:0]       len_at;
	logic [SW-1:0]       head_at;
	logic [QW-1:0]       idx_dist;
	logic [LW-1:0]       len_diff;
	logic                cand;
	logic                full;
	logic                st_we;
	logic                st_re;
	logic [AW-1:0]       st_waddr;
	logic [AW-1:0]       st_raddr;
	logic [ID_WIDTH-1:0] st_wdata;
	logic [ID_WIDTH-1:0] st_rdata;
	logic                cfg_wr;

	always_comb begin
		if (act_q == 4'd0) begin
			used_n = CW'(1);
		end else if (32'(act_q) > NUM_QUEUES) begin
			used_n = CW'(NUM_QUEUES);
		end else begin
			used_n = CW'(act_q);
		end
	end

	assign idx      = cnt_q[QW-1:0];
	assign len_at   = len_q[idx];
	assign head_at  = head_q[idx];
	assign idx_dist = (idx > org_q) ? idx - org_q : org_q - idx;
	assign len_diff = org_len_q - len_at;
	assign cand     = (org_len_q > len_at) && (DW'(len_diff) > DW'(thr_q));
	assign full     = 32'(best_len_q) >= QUEUE_DEPTH;

	assign st_we    = ((state_q == S_AWR) && !full) || (state_q == S_JWR);
	assign st_waddr = {best_q, wrap_slot(PW'(best_head_q) + PW'(best_len_q))};
	assign st_wdata = (state_q == S_AWR) ? id_q : st_rdata;

	always_comb begin
		if (state_q == S_JRD) begin
			st_re    = 1'b1;
			st_raddr = {org_q, wrap_slot(PW'(org_head_q) + PW'(org_len_q) - PW'(1))};
		end else begin
			st_re    = (state_q == S_DSCAN) && (cnt_q < used_n);
			st_raddr = {idx, head_at};
		end
	end

	sqdj_store #(
		.AW(AW),
		.DW(ID_WIDTH)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_ACTIVE_QUEUES:    prdata = {28'd0, act_q};
			REG_JOCKEY_THRESHOLD: prdata = {28'd0, thr_q};
			default:              prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACTIVE_QUEUES_RESET;
			thr_q <= JOCKEY_THRESHOLD_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ACTIVE_QUEUES:    act_q <= pwdata[3:0];
				REG_JOCKEY_THRESHOLD: thr_q <= pwdata[3:0];
				default:              act_q <= act_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			p_vld_s1 <= 1'b0;
			found_q  <= 1'b0;
			have_q   <= 1'b0;
			cnt_q    <= '0;
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_q[q] <= '0;
				len_q[q]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						id_q     <= ID_WIDTH'(item.customer_id);
						cnt_q    <= '0;
						found_q  <= 1'b0;
						have_q   <= 1'b0;
						p_vld_s1 <= 1'b0;
						state_q  <= (item.kind == KIND_ARRIVAL) ? S_ASCAN : S_DSCAN;
					end
				end
				S_ASCAN: begin
					if ((cnt_q == '0) || (len_at < best_len_q)) begin
						best_q      <= idx;
						best_len_q  <= len_at;
						best_head_q <= head_at;
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == used_n - CW'(1)) begin
						state_q <= S_AWR;
					end
				end
				S_AWR: begin
					res_q.jockey_moved  <= 1'b0;
					res_q.jockey_target <= 3'd0;
					res_q.moved_id      <= 16'd0;
					if (full) begin
						res_q.status      <= STATUS_FULL;
						res_q.queue_index <= 3'd0;
					end else begin
						len_q[best_q]     <= best_len_q + LW'(1);
						res_q.status      <= STATUS_DONE;
						res_q.queue_index <= 3'(best_q);
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_DSCAN: begin
					if (p_vld_s1 && (p_len_s1 != '0) && (st_rdata == id_q)) begin
						found_q    <= 1'b1;
						org_q      <= p_idx_s1;
						org_head_q <= p_head_s1;
						org_len_q  <= p_len_s1;
					end
					if (cnt_q < used_n) begin
						p_vld_s1  <= 1'b1;
						p_idx_s1  <= idx;
						p_head_s1 <= head_at;
						p_len_s1  <= len_at;
						cnt_q     <= cnt_q + CW'(1);
					end else begin
						p_vld_s1 <= 1'b0;
						state_q  <= S_DPOP;
					end
				end
				S_DPOP: begin
					if (!found_q) begin
						res_q.status        <= STATUS_NOT_FOUND;
						res_q.queue_index   <= 3'd0;
						res_q.jockey_moved  <= 1'b0;
						res_q.jockey_target <= 3'd0;
						res_q.moved_id      <= 16'd0;
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						head_q[org_q] <= wrap_slot(PW'(org_head_q) + PW'(1));
						len_q[org_q]  <= org_len_q - LW'(1);
						org_head_q    <= wrap_slot(PW'(org_head_q) + PW'(1));
						org_len_q     <= org_len_q - LW'(1);
						cnt_q         <= '0;
						state_q       <= S_JSCAN;
					end
				end
				S_JSCAN: begin
					if (cand && (!have_q || (idx_dist < best_dist_q))) begin
						have_q      <= 1'b1;
						best_q      <= idx;
						best_dist_q <= idx_dist;
						best_len_q  <= len_at;
						best_head_q <= head_at;
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == used_n - CW'(1)) begin
						state_q <= S_JRD;
					end
				end
				S_JRD: begin
					if (!have_q) begin
						res_q.status        <= STATUS_DONE;
						res_q.queue_index   <= 3'(org_q);
						res_q.jockey_moved  <= 1'b0;
						res_q.jockey_target <= 3'd0;
						res_q.moved_id      <= 16'd0;
						done_q              <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						state_q <= S_JWR;
					end
				end
				S_JWR: begin
					len_q[org_q]        <= org_len_q - LW'(1);
					len_q[best_q]       <= best_len_q + LW'(1);
					res_q.status        <= STATUS_DONE;
					res_q.queue_index   <= 3'(org_q);
					res_q.jockey_moved  <= 1'b1;
					res_q.jockey_target <= 3'(best_q);
					res_q.moved_id      <= 16'(st_rdata);
					done_q              <= 1'b1;
					state_q             <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- src/sqdj_store.sv -----
// ---------------------------------------------------------------------------
// sqdj_store: customer identifier store
// Single write port and one registered read port holding the entries of all
// queues, addressed by queue index and slot.
// ---------------------------------------------------------------------------
module sqdj_store #(
	parameter int AW = 7,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
